// ===== rtl/sfr_pkg.sv =====
// Shared types and constants of the serial frame receiver.
`default_nettype none

package sfr_pkg;

   // Link control bytes
   localparam logic [7:0] BYTE_NUL       = 8'h00;
   localparam logic [7:0] BYTE_SOH       = 8'h01;
   localparam logic [7:0] BYTE_STX       = 8'h02;
   localparam logic [7:0] BYTE_EOT       = 8'h04;
   localparam logic [7:0] BYTE_ENQ_START = 8'h31;

   // Format byte flags
   localparam int unsigned FMT_WIDE_ID_BIT = 2;
   localparam int unsigned FMT_WIDE_SZ_BIT = 1;

   // Stream widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 88;
   localparam int unsigned RSP_USER_W = 3;

   typedef enum logic [2:0] {
      EV_PAYLOAD  = 3'd0,
      EV_HEADER   = 3'd1,
      EV_TEXT     = 3'd2,
      EV_ENQUIRY  = 3'd3,
      EV_EOT      = 3'd4,
      EV_BAD_STX  = 3'd5,
      EV_UNKNOWN  = 3'd6
   } event_type;

   typedef struct packed {
      logic        valid;
      event_type   event_res;
      logic        send_reply;
      logic        reply_ok;
      logic [15:0] dest_id;
      logic [15:0] src_id;
      logic [7:0]  function_code;
      logic [16:0] payload_length;
      logic [7:0]  data_byte;
      logic [15:0] data_index;
      logic        last_payload;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/serial_frame_receiver_unit.sv =====
// Serial frame receiver top level: input register, parser and result register.
// A byte is first held in the input register; its result is then registered in the result register on rsp_*.
// Throughput: one byte per cycle while rsp_tready stays high; the parser state
// advances whenever the input register holds a byte and the result register can load.
// Bytes that give no result simply retire without occupying the result register.
// Reset (synchronous, active high) empties both registers and puts the parser at
// top level with no good header recorded.
`default_nettype none

module serial_frame_receiver_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: rx_byte[7:0]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sfr_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: send_reply[0], reply_ok[1], dest_id[17:2], src_id[33:18],
   //        function_code[41:34], payload_length[58:42], data_byte[66:59],
   //        data_index[82:67], zero fill[87:83]
   output logic [sfr_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // tuser: event_res[2:0]
   output logic [sfr_pkg::RSP_USER_W-1:0]         rsp_tuser,
   output logic                                   rsp_tlast
);
   import sfr_pkg::*;

   logic                  in_vld_ff;
   logic [REQ_DATA_W-1:0] in_byte_ff;
   logic                  out_free;
   logic                  step;
   result_type            result;

   // Input register moves on whenever the result side can take what it makes
   assign step       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   sfr_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   sfr_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (step && result.valid),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/sfr_parse.sv =====
// Frame parser: per-byte state update and result decode.
`default_nettype none

module sfr_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          rx_byte,
   output sfr_pkg::result_type      result
);
   import sfr_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_E_DST, PH_E_SRC, PH_E_CODE,
      PH_H_FMT, PH_H_DSTH, PH_H_DSTL, PH_H_SRCH, PH_H_SRCL,
      PH_H_FNC, PH_H_SIZH, PH_H_SIZL, PH_H_CKS,
      PH_T_DATA, PH_T_ETX, PH_T_CKS
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  format_ff, format_in;
   logic [15:0] dest_ff, dest_in;
   logic [15:0] src_ff, src_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] size_ff, size_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic [7:0]  enq_dest_ff, enq_dest_in;
   logic [7:0]  enq_src_ff, enq_src_in;

   logic [7:0]  sum_next;
   logic [16:0] plen;
   logic        last;

   assign sum_next = sum_ff + rx_byte;
   assign plen     = {1'b0, size_ff} + 17'd1;
   assign last     = (count_ff >= size_ff);

   always_comb begin
      phase_in    = phase_ff;
      format_in   = format_ff;
      dest_in     = dest_ff;
      src_in      = src_ff;
      func_in     = func_ff;
      size_in     = size_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      hdr_ok_in   = hdr_ok_ff;
      enq_dest_in = enq_dest_ff;
      enq_src_in  = enq_src_ff;
      result      = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == BYTE_NUL) begin
               phase_in = PH_IDLE;
            end else if (rx_byte == BYTE_ENQ_START) begin
               phase_in = PH_E_DST;
            end else if (rx_byte == BYTE_SOH) begin
               dest_in  = '0;
               src_in   = '0;
               size_in  = '0;
               sum_in   = BYTE_SOH;
               phase_in = PH_H_FMT;
            end else if (rx_byte == BYTE_STX) begin
               if (hdr_ok_ff) begin
                  sum_in   = BYTE_STX;
                  count_in = '0;
                  phase_in = PH_T_DATA;
               end else begin
                  result.valid     = 1'b1;
                  result.event_res = EV_BAD_STX;
               end
            end else if (rx_byte == BYTE_EOT) begin
               result.valid     = 1'b1;
               result.event_res = EV_EOT;
            end else begin
               result.valid     = 1'b1;
               result.event_res = EV_UNKNOWN;
               result.data_byte = rx_byte;
            end
         end
         PH_E_DST: begin
            enq_dest_in = rx_byte;
            phase_in    = PH_E_SRC;
         end
         PH_E_SRC: begin
            enq_src_in = rx_byte;
            phase_in   = PH_E_CODE;
         end
         PH_E_CODE: begin
            phase_in          = PH_IDLE;
            result.valid      = 1'b1;
            result.event_res  = EV_ENQUIRY;
            result.send_reply = 1'b1;
            result.reply_ok   = 1'b1;
            result.dest_id    = {8'h00, enq_dest_ff};
            result.src_id     = {8'h00, enq_src_ff};
            result.data_byte  = rx_byte;
         end
         PH_H_FMT: begin
            sum_in    = sum_next;
            format_in = rx_byte;
            phase_in  = rx_byte[FMT_WIDE_ID_BIT] ? PH_H_DSTH : PH_H_DSTL;
         end
         PH_H_DSTH: begin
            sum_in   = sum_next;
            dest_in  = {rx_byte, dest_ff[7:0]};
            phase_in = PH_H_DSTL;
         end
         PH_H_DSTL: begin
            sum_in   = sum_next;
            dest_in  = {dest_ff[15:8], rx_byte};
            phase_in = format_ff[FMT_WIDE_ID_BIT] ? PH_H_SRCH : PH_H_SRCL;
         end
         PH_H_SRCH: begin
            sum_in   = sum_next;
            src_in   = {rx_byte, src_ff[7:0]};
            phase_in = PH_H_SRCL;
         end
         PH_H_SRCL: begin
            sum_in   = sum_next;
            src_in   = {src_ff[15:8], rx_byte};
            phase_in = PH_H_FNC;
         end
         PH_H_FNC: begin
            sum_in   = sum_next;
            func_in  = rx_byte;
            phase_in = format_ff[FMT_WIDE_SZ_BIT] ? PH_H_SIZH : PH_H_SIZL;
         end
         PH_H_SIZH: begin
            sum_in   = sum_next;
            size_in  = {rx_byte, size_ff[7:0]};
            phase_in = PH_H_SIZL;
         end
         PH_H_SIZL: begin
            sum_in   = sum_next;
            size_in  = {size_ff[15:8], rx_byte};
            phase_in = PH_H_CKS;
         end
         PH_H_CKS: begin
            sum_in                = sum_next;
            hdr_ok_in             = (sum_next == 8'h00);
            phase_in              = PH_IDLE;
            result.valid          = 1'b1;
            result.event_res      = EV_HEADER;
            result.send_reply     = 1'b1;
            result.reply_ok       = (sum_next == 8'h00);
            result.dest_id        = dest_ff;
            result.src_id         = src_ff;
            result.function_code  = func_ff;
            result.payload_length = plen;
         end
         PH_T_DATA: begin
            sum_in                = sum_next;
            count_in              = count_ff + 16'd1;
            if (last) begin
               phase_in = PH_T_ETX;
            end
            result.valid          = 1'b1;
            result.event_res      = EV_PAYLOAD;
            result.dest_id        = dest_ff;
            result.src_id         = src_ff;
            result.function_code  = func_ff;
            result.payload_length = plen;
            result.data_byte      = rx_byte;
            result.data_index     = count_ff;
            result.last_payload   = last;
         end
         PH_T_ETX: begin
            // ETX value itself is not checked, only summed
            sum_in   = sum_next;
            phase_in = PH_T_CKS;
         end
         PH_T_CKS: begin
            sum_in                = sum_next;
            phase_in              = PH_IDLE;
            result.valid          = 1'b1;
            result.event_res      = EV_TEXT;
            result.send_reply     = 1'b1;
            result.reply_ok       = (sum_next == 8'h00);
            result.dest_id        = dest_ff;
            result.src_id         = src_ff;
            result.function_code  = func_ff;
            result.payload_length = plen;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         format_ff   <= '0;
         dest_ff     <= '0;
         src_ff      <= '0;
         func_ff     <= '0;
         size_ff     <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         hdr_ok_ff   <= 1'b0;
         enq_dest_ff <= '0;
         enq_src_ff  <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         format_ff   <= format_in;
         dest_ff     <= dest_in;
         src_ff      <= src_in;
         func_ff     <= func_in;
         size_ff     <= size_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         hdr_ok_ff   <= hdr_ok_in;
         enq_dest_ff <= enq_dest_in;
         enq_src_ff  <= enq_src_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sfr_rsp_stage.sv =====
// Result register driving the response stream.
`default_nettype none

module sfr_rsp_stage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire sfr_pkg::result_type               result,
   output logic                                   free,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sfr_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [sfr_pkg::RSP_USER_W-1:0]         rsp_tuser,
   output logic                                   rsp_tlast
);
   import sfr_pkg::*;

   logic       vld_ff;
   result_type res_ff;

   assign free = !vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (load) begin
         vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = res_ff.event_res;
   assign rsp_tlast  = res_ff.last_payload;
   assign rsp_tdata  = {5'b0, res_ff.data_index, res_ff.data_byte,
                        res_ff.payload_length, res_ff.function_code,
                        res_ff.src_id, res_ff.dest_id,
                        res_ff.reply_ok, res_ff.send_reply};

endmodule

`default_nettype wire
